>>> sv/rkt_pkg.sv
// Shared types, action and status codes for the reference-counted key table.
package rkt_pkg;

    localparam int TableDepth = 16;

    localparam int KeyW    = 64;
    localparam int CountW  = 64;
    localparam int PayW    = 64;
    localparam int ActionW = 2;
    localparam int StatusW = 2;

    typedef logic [ActionW-1:0] t_action;
    typedef logic [StatusW-1:0] t_status;

    localparam t_action OP_INSERT = 2'd0;
    localparam t_action OP_LOOKUP = 2'd1;
    localparam t_action OP_ADD    = 2'd2;
    localparam t_action OP_SET    = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_DUPLICATE = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

endpackage

>>> sv/refcounted_key_table.sv
// Reference-counted key table: parallel key compare over a register table.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall | action, region_key, payload, delta
//  out     | output    | o_out_valid/ i_out_stall| status, count, payload, freed
//
//  One word per cycle sustained while the output does not stall. A word passes the
//  input register, then the result register (outcome of the single compare pass).
//  Throughput is set by the key compare, the count add and the table write,
//  which all fit between the input register and the result register.
//  Reset (synchronous, active low) clears the slot valid bits and both
//  pipeline valids; slot contents are left as they are.
//  A stall on the output holds the result register and, through it, the
//  input register; the input stalls only when its register cannot advance.
module refcounted_key_table #(
    parameter int TABLE_DEPTH = rkt_pkg::TableDepth
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  rkt_pkg::t_action            i_action,
    input  logic [rkt_pkg::KeyW-1:0]    i_region_key,
    input  logic [rkt_pkg::PayW-1:0]    i_payload_in,
    input  logic [rkt_pkg::CountW-1:0]  i_count_delta,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output rkt_pkg::t_status            o_status,
    output logic [rkt_pkg::CountW-1:0]  o_count_out,
    output logic [rkt_pkg::PayW-1:0]    o_payload_out,
    output logic                        o_freed
);

    // Input register.
    logic                        r_in_valid;
    rkt_pkg::t_action            r_action;
    logic [rkt_pkg::KeyW-1:0]    r_key;
    logic [rkt_pkg::PayW-1:0]    r_payload;
    logic [rkt_pkg::CountW-1:0]  r_delta;

    // Result register.
    logic                        r_out_valid;
    rkt_pkg::t_status            r_status;
    logic [rkt_pkg::CountW-1:0]  r_count_out;
    logic [rkt_pkg::PayW-1:0]    r_payload_out;
    logic                        r_freed;

    // Slot table.
    logic [TABLE_DEPTH-1:0]      r_slot_valid;
    logic [rkt_pkg::KeyW-1:0]    r_slot_key     [TABLE_DEPTH];
    logic [rkt_pkg::CountW-1:0]  r_slot_count   [TABLE_DEPTH];
    logic [rkt_pkg::PayW-1:0]    r_slot_payload [TABLE_DEPTH];

    // Compare pass.
    logic [TABLE_DEPTH-1:0]      hit_vec;
    logic                        hit_any;
    logic [TABLE_DEPTH-1:0]      free_vec;
    logic                        table_full;
    logic [rkt_pkg::CountW-1:0]  sel_count;
    logic [rkt_pkg::PayW-1:0]    sel_payload;
    logic [rkt_pkg::CountW-1:0]  sum_count;
    logic                        sum_zero;

    // Execute decision and next result.
    logic                        exec;
    logic                        ins_en;
    logic                        add_en;
    logic                        set_en;
    rkt_pkg::t_status            n_status;
    logic [rkt_pkg::CountW-1:0]  n_count_out;
    logic [rkt_pkg::PayW-1:0]    n_payload_out;
    logic                        n_freed;
    logic [TABLE_DEPTH-1:0]      n_slot_valid;

    // Advance the input word when the result register is free or draining.
    assign exec       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec;

    // Parallel key compare; at most one valid slot can match.
    always_comb begin
        hit_vec     = '0;
        sel_count   = '0;
        sel_payload = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit_vec[i] = r_slot_valid[i] && (r_slot_key[i] == r_key);
            if (hit_vec[i]) begin
                sel_count   = sel_count | r_slot_count[i];
                sel_payload = sel_payload | r_slot_payload[i];
            end
        end
    end

    assign hit_any    = |hit_vec;
    assign table_full = &r_slot_valid;
    // Lowest clear valid bit, one-hot.
    assign free_vec   = ~r_slot_valid & (r_slot_valid + TABLE_DEPTH'(1));
    assign sum_count  = sel_count + r_delta;
    assign sum_zero   = (sum_count == '0);

    // Decode the action against the compare outcome.
    always_comb begin
        ins_en        = 1'b0;
        add_en        = 1'b0;
        set_en        = 1'b0;
        n_status      = rkt_pkg::ST_OK;
        n_count_out   = '0;
        n_payload_out = '0;
        n_freed       = 1'b0;
        unique case (r_action)
            rkt_pkg::OP_INSERT: begin
                if (hit_any) begin
                    n_status = rkt_pkg::ST_DUPLICATE;
                end else if (table_full) begin
                    n_status = rkt_pkg::ST_FULL;
                end else begin
                    ins_en        = 1'b1;
                    n_payload_out = r_payload;
                end
            end
            rkt_pkg::OP_LOOKUP: begin
                if (!hit_any) begin
                    n_status = rkt_pkg::ST_NOT_FOUND;
                end else begin
                    n_count_out   = sel_count;
                    n_payload_out = sel_payload;
                end
            end
            rkt_pkg::OP_ADD: begin
                if (!hit_any) begin
                    n_status = rkt_pkg::ST_NOT_FOUND;
                end else begin
                    add_en        = 1'b1;
                    n_count_out   = sum_count;
                    n_payload_out = sel_payload;
                    n_freed       = sum_zero;
                end
            end
            rkt_pkg::OP_SET: begin
                if (!hit_any) begin
                    n_status = rkt_pkg::ST_NOT_FOUND;
                end else begin
                    set_en        = 1'b1;
                    n_count_out   = sel_count;
                    n_payload_out = r_payload;
                end
            end
            default: begin
                n_status = rkt_pkg::ST_OK;
            end
        endcase
    end

    // Set the new slot on insert, drop the matching slot when its count hits zero.
    always_comb begin
        n_slot_valid = r_slot_valid;
        if (exec && ins_en) begin
            n_slot_valid = r_slot_valid | free_vec;
        end else if (exec && add_en && sum_zero) begin
            n_slot_valid = r_slot_valid & ~hit_vec;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slot_valid <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_slot_valid <= n_slot_valid;
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action  <= i_action;
            r_key     <= i_region_key;
            r_payload <= i_payload_in;
            r_delta   <= i_count_delta;
        end
    end

    // Result word capture.
    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status      <= n_status;
            r_count_out   <= n_count_out;
            r_payload_out <= n_payload_out;
            r_freed       <= n_freed;
        end
    end

    // Slot contents: one writer per slot per cycle (insert goes to a free slot,
    // add and set go to the matching one).
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (exec && ins_en && free_vec[i]) begin
                r_slot_key[i]     <= r_key;
                r_slot_count[i]   <= '0;
                r_slot_payload[i] <= r_payload;
            end
            if (exec && add_en && hit_vec[i]) begin
                r_slot_count[i] <= sum_count;
            end
            if (exec && set_en && hit_vec[i]) begin
                r_slot_payload[i] <= r_payload;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_count_out   = r_count_out;
    assign o_payload_out = r_payload_out;
    assign o_freed       = r_freed;

endmodule

>>> sv/rkt_checker.sv
// Port-level checker for the reference-counted key table, with its bind.
module rkt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  rkt_pkg::t_status            o_status,
    input  logic [rkt_pkg::CountW-1:0]  o_count_out,
    input  logic [rkt_pkg::PayW-1:0]    o_payload_out,
    input  logic                        o_freed
);

    // No result word right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_count_out)
            && $stable(o_payload_out) && $stable(o_freed))
        else $error("stalled result word changed");

    // A freed entry always reports ok with a zero count.
    a_freed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_freed |->
            (o_status == rkt_pkg::ST_OK) && (o_count_out == '0))
        else $error("freed reported without ok status and zero count");

    // Any failing status returns zeros.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != rkt_pkg::ST_OK) |->
            (o_count_out == '0) && (o_payload_out == '0) && !o_freed)
        else $error("failing status with nonzero result fields");

    // Input never stalls while the output side is empty of results.
    a_in_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind refcounted_key_table rkt_checker u_rkt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_count_out   (o_count_out),
    .o_payload_out (o_payload_out),
    .o_freed       (o_freed)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the reference-counted key table.
`timescale 1ns / 1ps

module testbench;

    // Quiet cycles tolerated with no word moving on either channel.
    localparam int WatchdogLimit = 2000;
    // Keys that random traffic keeps coming back to, so hits are frequent.
    localparam int PoolSize = 24;
    localparam int SegmentItems = 80;

    typedef struct packed {
        rkt_pkg::t_status                 status;
        logic [rkt_pkg::CountW-1:0]       count;
        logic [rkt_pkg::PayW-1:0]         payload;
        logic                             freed;
    } t_table_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_stall;
    rkt_pkg::t_action                 i_action;
    logic [rkt_pkg::KeyW-1:0]         i_region_key;
    logic [rkt_pkg::PayW-1:0]         i_payload_in;
    logic [rkt_pkg::CountW-1:0]       i_count_delta;
    logic                             o_out_valid;
    logic                             i_out_stall;
    rkt_pkg::t_status                 o_status;
    logic [rkt_pkg::CountW-1:0]       o_count_out;
    logic [rkt_pkg::PayW-1:0]         o_payload_out;
    logic                             o_freed;

    // Shadow copy of the table, updated as each word is accepted.
    logic                             live_bit[rkt_pkg::TableDepth];
    logic [rkt_pkg::KeyW-1:0]         key_store[rkt_pkg::TableDepth];
    logic [rkt_pkg::CountW-1:0]       count_store[rkt_pkg::TableDepth];
    logic [rkt_pkg::PayW-1:0]         payload_store[rkt_pkg::TableDepth];

    // Outcomes still owed by the block, oldest first.
    t_table_result                    expected_outcomes[$];
    logic [rkt_pkg::KeyW-1:0]         key_pool[PoolSize];

    int                               fail_count = 0;
    int                               quiet_cycles = 0;
    bit                               in_gaps = 1'b1;
    bit                               stall_bursts = 1'b1;

    refcounted_key_table #(
        .TABLE_DEPTH(rkt_pkg::TableDepth)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_region_key  (i_region_key),
        .i_payload_in  (i_payload_in),
        .i_count_delta (i_count_delta),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_count_out   (o_count_out),
        .o_payload_out (o_payload_out),
        .o_freed       (o_freed)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Apply one operation to the shadow table and return the word the block owes.
    // A key can match at most one live slot; inserts take the lowest free slot.
    function automatic t_table_result apply_table_op(
        rkt_pkg::t_action op, logic [rkt_pkg::KeyW-1:0] key,
        logic [rkt_pkg::PayW-1:0] pay, logic [rkt_pkg::CountW-1:0] delta);
        t_table_result res;
        int hit;
        int free_slot;
        res = '0;
        res.status = rkt_pkg::ST_OK;
        hit = -1;
        free_slot = -1;
        // Scan downward so both indexes end on the lowest qualifying slot.
        for (int s = rkt_pkg::TableDepth - 1; s >= 0; s--) begin
            if (live_bit[s] && key_store[s] == key) hit = s;
            if (!live_bit[s]) free_slot = s;
        end
        if (op == rkt_pkg::OP_INSERT) begin
            if (hit >= 0) begin
                res.status = rkt_pkg::ST_DUPLICATE;
            end else if (free_slot < 0) begin
                res.status = rkt_pkg::ST_FULL;
            end else begin
                live_bit[free_slot]      = 1'b1;
                key_store[free_slot]     = key;
                count_store[free_slot]   = '0;
                payload_store[free_slot] = pay;
                res.payload              = pay;
            end
        end else if (hit < 0) begin
            res.status = rkt_pkg::ST_NOT_FOUND;
        end else if (op == rkt_pkg::OP_LOOKUP) begin
            res.count   = count_store[hit];
            res.payload = payload_store[hit];
        end else if (op == rkt_pkg::OP_ADD) begin
            // Wrap at 64 bits; an entry whose count lands on zero is released.
            count_store[hit] = count_store[hit] + delta;
            res.count        = count_store[hit];
            res.payload      = payload_store[hit];
            if (count_store[hit] == '0) begin
                live_bit[hit] = 1'b0;
                res.freed     = 1'b1;
            end
        end else begin
            payload_store[hit] = pay;
            res.count          = count_store[hit];
            res.payload        = pay;
        end
        return res;
    endfunction

    // Send one word: optionally idle first, then hold valid until the block takes it.
    task automatic send_word(input rkt_pkg::t_action op,
                             input logic [rkt_pkg::KeyW-1:0] key,
                             input logic [rkt_pkg::PayW-1:0] pay,
                             input logic [rkt_pkg::CountW-1:0] delta);
        if (in_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= op;
        i_region_key  <= key;
        i_payload_in  <= pay;
        i_count_delta <= delta;
        do @(posedge i_clk); while (o_in_stall);
        // Predict in acceptance order, which is the order results come back in.
        expected_outcomes.push_back(apply_table_op(op, key, pay, delta));
    endtask

    // Drop valid and wait until every owed word has come back; always advances a cycle.
    task automatic drain_outcomes();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_outcomes.size() != 0);
    endtask

    // One random word, mostly aimed at pool keys; deltas often zero out the count.
    task automatic send_random_word();
        rkt_pkg::t_action                 op;
        logic [rkt_pkg::KeyW-1:0]         key;
        logic [rkt_pkg::CountW-1:0]       delta;
        int                               pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) op = rkt_pkg::OP_INSERT;
        else if (pick < 5) op = rkt_pkg::OP_LOOKUP;
        else if (pick < 8) op = rkt_pkg::OP_ADD;
        else op = rkt_pkg::OP_SET;
        // Mostly pool keys; a stray key now and then to exercise misses.
        if ($urandom_range(0, 9) == 0) key = rand64();
        else key = key_pool[$urandom_range(0, PoolSize - 1)];
        case ($urandom_range(0, 4))
            0: begin
                // Cancel the current count exactly so the entry gets released.
                delta = rand64();
                for (int s = 0; s < rkt_pkg::TableDepth; s++) begin
                    if (live_bit[s] && key_store[s] == key) delta = '0 - count_store[s];
                end
            end
            1: delta = rkt_pkg::CountW'($urandom_range(1, 3));
            2: delta = '1;
            3: delta = '0;
            default: delta = rand64();
        endcase
        send_word(op, key, rand64(), delta);
    endtask

    // Misses on an empty table, with extreme keys.
    task automatic test_empty_table();
        send_word(rkt_pkg::OP_LOOKUP, '0, '1, '1);
        send_word(rkt_pkg::OP_ADD, '1, '0, '1);
        send_word(rkt_pkg::OP_SET, '1, '1, '0);
    endtask

    // Every operation once or more, duplicate insert, wrap, and both ways to free.
    task automatic test_basic_ops();
        send_word(rkt_pkg::OP_INSERT, '0, '1, '0);
        send_word(rkt_pkg::OP_INSERT, '1, '0, '1);
        send_word(rkt_pkg::OP_INSERT, '0, 64'h1234_5678_9abc_def0, '0);
        send_word(rkt_pkg::OP_LOOKUP, '0, '0, '0);
        send_word(rkt_pkg::OP_SET, '1, '1, '0);
        send_word(rkt_pkg::OP_ADD, '1, '0, '1);
        send_word(rkt_pkg::OP_LOOKUP, '1, '0, '0);
        // Count is all ones: one more wraps it to zero and frees the entry.
        send_word(rkt_pkg::OP_ADD, '1, '0, 64'd1);
        // Zero delta on a zero count frees too.
        send_word(rkt_pkg::OP_ADD, '0, '0, '0);
        send_word(rkt_pkg::OP_LOOKUP, '0, '0, '0);
    endtask

    // Fill every slot, hit the full and duplicate paths, reuse a freed slot, empty it.
    task automatic test_table_full();
        logic [rkt_pkg::KeyW-1:0] fill_keys[rkt_pkg::TableDepth];
        logic [rkt_pkg::KeyW-1:0] extra_key;
        int                       hole;
        for (int s = 0; s < rkt_pkg::TableDepth; s++) begin
            fill_keys[s]      = rand64();
            fill_keys[s][7:0] = 8'(s);
            send_word(rkt_pkg::OP_INSERT, fill_keys[s], rand64(), '0);
        end
        extra_key       = rand64();
        extra_key[7:0]  = 8'hff;
        send_word(rkt_pkg::OP_INSERT, extra_key, rand64(), '0);
        send_word(rkt_pkg::OP_INSERT, fill_keys[3], rand64(), '0);
        // Punch a hole in the middle; the next insert must land there.
        hole = rkt_pkg::TableDepth / 2;
        send_word(rkt_pkg::OP_ADD, fill_keys[hole], '0, '0);
        send_word(rkt_pkg::OP_INSERT, extra_key, rand64(), '0);
        fill_keys[hole] = extra_key;
        send_word(rkt_pkg::OP_SET, extra_key, rand64(), '0);
        send_word(rkt_pkg::OP_LOOKUP, extra_key, '0, '0);
        for (int s = 0; s < rkt_pkg::TableDepth; s++) begin
            send_word(rkt_pkg::OP_ADD, fill_keys[s], '0, '0);
        end
    endtask

    // Long random run in segments; idling changes per segment, one full drain midway.
    task automatic test_random_traffic();
        for (int p = 0; p < PoolSize; p++) key_pool[p] = rand64();
        for (int seg = 0; seg < 8; seg++) begin
            in_gaps      = $urandom_range(0, 1);
            stall_bursts = $urandom_range(0, 1);
            if (seg == 4) drain_outcomes();
            repeat (SegmentItems) send_random_word();
        end
    endtask

    // Back-to-back words with no idling on either side.
    task automatic test_quiet_tail();
        in_gaps      = 1'b0;
        stall_bursts = 1'b0;
        repeat (SegmentItems) send_random_word();
    endtask

    // Output stall in random bursts while enabled.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_bursts && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result word with the oldest outcome owed.
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outcomes.size() == 0) begin
                $error("result word with no outcome owed: status %0d", o_status);
                fail_count++;
            end else begin
                want = expected_outcomes.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_count_out !== want.count) begin
                    $error("count_out: expected %h, actual %h", want.count, o_count_out);
                    fail_count++;
                end
                if (o_payload_out !== want.payload) begin
                    $error("payload_out: expected %h, actual %h", want.payload, o_payload_out);
                    fail_count++;
                end
                if (o_freed !== want.freed) begin
                    $error("freed: expected %0d, actual %0d", want.freed, o_freed);
                    fail_count++;
                end
            end
        end
    end

    // Abort when no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= rkt_pkg::OP_LOOKUP;
        i_region_key  <= '0;
        i_payload_in  <= '0;
        i_count_delta <= '0;
        for (int s = 0; s < rkt_pkg::TableDepth; s++) live_bit[s] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_basic_ops();
        test_table_full();
        test_random_traffic();
        test_quiet_tail();

        // Hold off until all owed words are back, then let the pipeline settle.
        drain_outcomes();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rkt_pkg.sv
sv/refcounted_key_table.sv
sv/rkt_checker.sv
tb/sv/testbench.sv
